// File: rtl/core/mie_pkg.sv
// ----------------------------------------------------------------------------
// mie_pkg
// Shared types, constants and command structures of the integer execute unit.
// ----------------------------------------------------------------------------
package mie_pkg;

    localparam logic [63:0] RESET_PC = 64'h0000_0000_1fc0_0000;

    // Long operation classes: none, multiply or divide.
    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_MUL  = 3'd1,
        OP_DIV  = 3'd2
    } t_long_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic read_regs;   // Register-file read of rs and rt.
        logic execute;     // Evaluate the decoded instruction.
        logic long_start;  // Start the multiply or divide unit.
        logic commit;      // Write back state and present the result.
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_long;     // The instruction needs the multiply or divide unit.
        logic long_done;   // The multiply or divide unit has finished.
    } t_status;

    function automatic logic [63:0] sx32(input logic [63:0] x);
        return {{32{x[31]}}, x[31:0]};
    endfunction

endpackage

// File: rtl/core/mie_muldiv.sv
// ----------------------------------------------------------------------------
// mie_muldiv
// Iterative multiply and divide unit: one bit per cycle, 64 steps.
// ----------------------------------------------------------------------------
module mie_muldiv (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic         i_is_div,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_done,
    output logic [63:0]  o_q,
    output logic [63:0]  o_r
);
    logic [6:0]   r_cnt, n_cnt;
    logic         r_busy, n_busy;
    logic         r_div;
    logic [63:0]  r_x;     // Multiplier shift or quotient.
    logic [63:0]  r_y;     // Multiplicand or divisor.
    logic [63:0]  r_acc;   // Product high word or remainder.
    logic [64:0]  w_sum;
    logic [65:0]  w_trial;

    assign w_sum   = {1'b0, r_acc} + {1'b0, (r_x[0] ? r_y : 64'd0)};
    // The shifted remainder can reach 65 bits when the divisor is above 2^63.
    assign w_trial = {1'b0, r_acc, r_x[63]} - {2'b00, r_y};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 7'd0;
        end else if (r_busy) begin
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 7'd0;
            o_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            o_done <= r_busy && (r_cnt == 7'd63);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_is_div;
            r_x   <= i_a;
            r_y   <= i_b;
            r_acc <= 64'd0;
        end else if (r_busy) begin
            if (r_div) begin
                if (!w_trial[65]) begin
                    r_acc <= w_trial[63:0];
                    r_x   <= {r_x[62:0], 1'b1};
                end else begin
                    r_acc <= {r_acc[62:0], r_x[63]};
                    r_x   <= {r_x[62:0], 1'b0};
                end
            end else begin
                // Shift-add: product high in acc, low bits shift into x.
                r_acc <= w_sum[64:1];
                r_x   <= {w_sum[0], r_x[63:1]};
            end
        end
    end

    assign o_q = r_x;
    assign o_r = r_acc;
endmodule

// File: rtl/core/mie_datapath.sv
// ----------------------------------------------------------------------------
// mie_datapath
// Register files, PC, decode and ALU of the integer execute unit.
// ----------------------------------------------------------------------------
module mie_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [31:0]     i_instr,
    input  logic            i_load,
    input  mie_pkg::t_cmd   i_cmd,
    output mie_pkg::t_status o_status,
    output logic [63:0]     o_next_pc,
    output logic            o_reg_written,
    output logic [4:0]      o_reg_index,
    output logic [63:0]     o_reg_value,
    output logic            o_unsupported
);
    localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

    logic [63:0] r_gpr [32];
    logic [63:0] r_cp0 [32];
    logic [31:0] r_gpr_valid;
    logic [31:0] r_cp0_valid;
    logic [63:0] r_hi, r_lo, r_pc, r_dtgt;
    logic        r_dslot;
    logic [31:0] r_op;
    logic [63:0] r_a, r_b, r_c0;

    // Results of the execute step.
    logic        r_wf;
    logic [4:0]  r_wi;
    logic [63:0] r_wv;
    logic        r_bad, r_tk, r_skip;
    logic [63:0] r_dest;
    logic        r_hiw, r_low;
    logic [63:0] r_hiv, r_lov;
    logic        r_c0w;
    logic [63:0] r_c0v;

    // Long operation context.
    logic        r_long, r_ldiv, r_l32, r_lsgn, r_na, r_nb, r_lzero;
    logic [63:0] r_la, r_lb;

    logic        n_wf, n_bad, n_tk, n_skip, n_hiw, n_low, n_c0w, n_long, n_ldiv;
    logic        n_l32, n_lsgn;
    logic [4:0]  n_wi;
    logic [63:0] n_wv, n_dest, n_hiv, n_lov, n_c0v;

    logic [4:0]  w_rs, w_rt, w_rd, w_sa;
    logic [63:0] w_imm, w_uimm, w_cur, w_s, w_off;
    logic [63:0] w_ma, w_mb, w_q, w_r, w_p, w_h;
    logic        w_ldone;

    assign w_rs   = r_op[25:21];
    assign w_rt   = r_op[20:16];
    assign w_rd   = r_op[15:11];
    assign w_sa   = r_op[10:6];
    assign w_imm  = {{48{r_op[15]}}, r_op[15:0]};
    assign w_uimm = {48'd0, r_op[15:0]};
    assign w_cur  = r_pc;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_op <= i_instr;
        end
        if (i_cmd.read_regs) begin
            r_a  <= r_gpr_valid[w_rs] ? r_gpr[w_rs] : 64'd0;
            r_b  <= r_gpr_valid[w_rt] ? r_gpr[w_rt] : 64'd0;
            r_c0 <= r_cp0_valid[w_rd] ? r_cp0[w_rd] : 64'd0;
        end
    end

    always_comb begin
        n_wf = 1'b0; n_wi = 5'd0; n_wv = 64'd0; n_bad = 1'b0;
        n_tk = 1'b0; n_skip = 1'b0; n_dest = 64'd0;
        n_hiw = 1'b0; n_low = 1'b0; n_hiv = 64'd0; n_lov = 64'd0;
        n_c0w = 1'b0; n_c0v = 64'd0;
        n_long = 1'b0; n_ldiv = 1'b0; n_l32 = 1'b0; n_lsgn = 1'b0;
        w_s = 64'd0;
        w_off = (w_imm << 2) + w_cur + 64'd4;
        unique case (r_op[31:26])
            6'd0: begin
                n_wi = w_rd; n_wf = 1'b1;
                unique case (r_op[5:0])
                    6'd0:  n_wv = mie_pkg::sx32(r_b << w_sa);
                    6'd2:  n_wv = mie_pkg::sx32({32'd0, r_b[31:0]} >> w_sa);
                    6'd3:  n_wv = mie_pkg::sx32(64'($signed(mie_pkg::sx32(r_b)) >>> w_sa));
                    6'd4:  n_wv = mie_pkg::sx32(r_b << r_a[4:0]);
                    6'd6:  n_wv = mie_pkg::sx32({32'd0, r_b[31:0]} >> r_a[4:0]);
                    6'd7:  n_wv = mie_pkg::sx32(
                               64'($signed(mie_pkg::sx32(r_b)) >>> r_a[4:0]));
                    6'd8:  begin n_wf = 1'b0; n_tk = 1'b1; n_dest = r_a; end
                    6'd9:  begin n_tk = 1'b1; n_dest = r_a; n_wv = w_cur + 64'd8; end
                    6'd15: n_wf = 1'b0;
                    6'd16: n_wv = r_hi;
                    6'd17: begin n_wf = 1'b0; n_hiw = 1'b1; n_hiv = r_a; end
                    6'd18: n_wv = r_lo;
                    6'd19: begin n_wf = 1'b0; n_low = 1'b1; n_lov = r_a; end
                    6'd20: n_wv = r_b << r_a[5:0];
                    6'd22: n_wv = r_b >> r_a[5:0];
                    6'd23: n_wv = 64'($signed(r_b) >>> r_a[5:0]);
                    6'd24, 6'd25, 6'd28, 6'd29: begin
                        n_wf = 1'b0; n_long = 1'b1;
                        n_l32 = !r_op[2]; n_lsgn = !r_op[0];
                    end
                    6'd26, 6'd27, 6'd30, 6'd31: begin
                        n_wf = 1'b0; n_long = 1'b1; n_ldiv = 1'b1;
                        n_l32 = !r_op[2]; n_lsgn = !r_op[0];
                    end
                    6'd32: begin
                        w_s = {32'd0, r_a[31:0] + r_b[31:0]};
                        if ((r_a[31] ~^ r_b[31]) && (r_a[31] ^ w_s[31])) begin
                            n_bad = 1'b1; n_wf = 1'b0;
                        end
                        n_wv = mie_pkg::sx32(w_s);
                    end
                    6'd33: n_wv = mie_pkg::sx32(r_a + r_b);
                    6'd34: begin
                        w_s = {32'd0, r_a[31:0] - r_b[31:0]};
                        if ((r_a[31] ^ r_b[31]) && (r_a[31] ^ w_s[31])) begin
                            n_bad = 1'b1; n_wf = 1'b0;
                        end
                        n_wv = mie_pkg::sx32(w_s);
                    end
                    6'd35: n_wv = mie_pkg::sx32(r_a - r_b);
                    6'd36: n_wv = r_a & r_b;
                    6'd37: n_wv = r_a | r_b;
                    6'd38: n_wv = r_a ^ r_b;
                    6'd39: n_wv = ~(r_a | r_b);
                    6'd42: n_wv = {63'd0, $signed(r_a) < $signed(r_b)};
                    6'd43: n_wv = {63'd0, r_a < r_b};
                    6'd44: begin
                        w_s = r_a + r_b;
                        if (((r_a ^ w_s) & (r_b ^ w_s) & SIGN64) != 64'd0) begin
                            n_bad = 1'b1; n_wf = 1'b0;
                        end
                        n_wv = w_s;
                    end
                    6'd45: n_wv = r_a + r_b;
                    6'd46: begin
                        w_s = r_a - r_b;
                        if (((r_a ^ r_b) & (r_a ^ w_s) & SIGN64) != 64'd0) begin
                            n_bad = 1'b1; n_wf = 1'b0;
                        end
                        n_wv = w_s;
                    end
                    6'd47: n_wv = r_a - r_b;
                    6'd56: n_wv = r_b << w_sa;
                    6'd58: n_wv = r_b >> w_sa;
                    6'd59: n_wv = 64'($signed(r_b) >>> w_sa);
                    6'd60: n_wv = r_b << ({1'b0, w_sa} + 6'd32);
                    6'd62: n_wv = r_b >> ({1'b0, w_sa} + 6'd32);
                    6'd63: n_wv = 64'($signed(r_b) >>> ({1'b0, w_sa} + 6'd32));
                    default: begin n_bad = 1'b1; n_wf = 1'b0; end
                endcase
            end
            6'd1: begin
                if (w_rt > 5'd19 || w_rt[3:2] != 2'd0) begin
                    n_bad = 1'b1;
                end else begin
                    n_tk   = w_rt[0] ? !r_a[63] : r_a[63];
                    n_skip = !n_tk && w_rt[1];
                    n_dest = w_off;
                    if (w_rt[4]) begin
                        n_wf = 1'b1; n_wi = 5'd31; n_wv = w_cur + 64'd8;
                    end
                end
            end
            6'd2, 6'd3: begin
                n_tk = 1'b1;
                n_dest = {w_s[63:28] | (w_cur[63:28] + 36'(w_cur[27:2] == 26'h3ffffff)),
                          r_op[25:0], 2'b00};
                if (r_op[26]) begin
                    n_wf = 1'b1; n_wi = 5'd31; n_wv = w_cur + 64'd8;
                end
            end
            6'd4, 6'd5, 6'd6, 6'd7, 6'd20, 6'd21, 6'd22, 6'd23: begin
                unique case (r_op[27:26])
                    2'd0: n_tk = (r_a == r_b);
                    2'd1: n_tk = (r_a != r_b);
                    2'd2: n_tk = (r_a == 64'd0) || r_a[63];
                    default: n_tk = (r_a != 64'd0) && !r_a[63];
                endcase
                n_skip = !n_tk && r_op[30];
                n_dest = w_off;
            end
            6'd8: begin
                w_s = {32'd0, r_a[31:0] + w_imm[31:0]};
                n_wi = w_rt;
                if ((r_a[31] ~^ w_imm[31]) && (r_a[31] ^ w_s[31])) begin
                    n_bad = 1'b1;
                end else begin
                    n_wf = 1'b1; n_wv = mie_pkg::sx32(w_s);
                end
            end
            6'd9:  begin n_wf = 1'b1; n_wi = w_rt; n_wv = mie_pkg::sx32(r_a + w_imm); end
            6'd10: begin
                n_wf = 1'b1; n_wi = w_rt; n_wv = {63'd0, $signed(r_a) < $signed(w_imm)};
            end
            6'd11: begin n_wf = 1'b1; n_wi = w_rt; n_wv = {63'd0, r_a < w_imm}; end
            6'd12: begin n_wf = 1'b1; n_wi = w_rt; n_wv = r_a & w_uimm; end
            6'd13: begin n_wf = 1'b1; n_wi = w_rt; n_wv = r_a | w_uimm; end
            6'd14: begin n_wf = 1'b1; n_wi = w_rt; n_wv = r_a ^ w_uimm; end
            6'd15: begin
                n_wf = 1'b1; n_wi = w_rt; n_wv = {{32{r_op[15]}}, r_op[15:0], 16'd0};
            end
            6'd16: begin
                unique case (w_rs)
                    5'd0: begin n_wf = 1'b1; n_wi = w_rt; n_wv = mie_pkg::sx32(r_c0); end
                    5'd1: begin n_wf = 1'b1; n_wi = w_rt; n_wv = r_c0; end
                    5'd4: begin n_c0w = 1'b1; n_c0v = mie_pkg::sx32(r_b); end
                    5'd5: begin n_c0w = 1'b1; n_c0v = r_b; end
                    default: n_bad = 1'b1;
                endcase
            end
            6'd24: begin
                w_s = r_a + w_imm;
                n_wi = w_rt;
                if (((r_a ^ w_s) & (w_imm ^ w_s) & SIGN64) != 64'd0) begin
                    n_bad = 1'b1;
                end else begin
                    n_wf = 1'b1; n_wv = w_s;
                end
            end
            6'd25: begin n_wf = 1'b1; n_wi = w_rt; n_wv = r_a + w_imm; end
            default: n_bad = 1'b1;
        endcase
        if (n_wi == 5'd0) begin
            n_wf = 1'b0;
        end
        if (!n_wf) begin
            n_wi = 5'd0; n_wv = 64'd0;
        end
    end

    // Operand preparation for the iterative unit: extended inputs, and their magnitudes for divide.
    logic [63:0] w_ea, w_eb;
    logic        w_sa_neg, w_sb_neg;
    always_comb begin
        w_ea = r_l32 ? (r_lsgn ? mie_pkg::sx32(r_a) : {32'd0, r_a[31:0]}) : r_a;
        w_eb = r_l32 ? (r_lsgn ? mie_pkg::sx32(r_b) : {32'd0, r_b[31:0]}) : r_b;
        w_sa_neg = r_lsgn && w_ea[63];
        w_sb_neg = r_lsgn && w_eb[63];
        w_ma = w_sa_neg ? (64'd0 - w_ea) : w_ea;
        w_mb = w_sb_neg ? (64'd0 - w_eb) : w_eb;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_wf <= n_wf; r_wi <= n_wi; r_wv <= n_wv; r_bad <= n_bad;
            r_tk <= n_tk; r_skip <= n_skip; r_dest <= n_dest;
            r_hiw <= n_hiw; r_low <= n_low; r_hiv <= n_hiv; r_lov <= n_lov;
            r_c0w <= n_c0w; r_c0v <= n_c0v;
            r_long <= n_long; r_ldiv <= n_ldiv; r_l32 <= n_l32; r_lsgn <= n_lsgn;
        end
        if (i_cmd.long_start) begin
            r_la <= w_ea; r_lb <= w_eb;
            r_na <= w_sa_neg; r_nb <= w_sb_neg;
            r_lzero <= (w_eb == 64'd0);
        end
    end

    mie_muldiv u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.long_start),
        .i_is_div (r_ldiv),
        .i_a      (r_ldiv ? w_ma : w_ea),
        .i_b      (r_ldiv ? w_mb : w_eb),
        .o_done   (w_ldone),
        .o_q      (w_q),
        .o_r      (w_r)
    );

    // Final HI/LO of a long operation.
    logic [63:0] w_lhi, w_llo, w_p32;
    always_comb begin
        w_p = w_q;
        w_h = w_r;
        w_p32 = 64'd0;
        if (r_ldiv) begin
            if (r_lzero) begin
                w_llo = r_na ? 64'd1 : '1;
                w_lhi = r_la;
            end else begin
                w_llo = (r_na != r_nb) ? (64'd0 - w_q) : w_q;
                w_lhi = r_na ? (64'd0 - w_r) : w_r;
            end
            if (r_l32) begin
                w_llo = r_lzero ? w_llo : mie_pkg::sx32(w_llo);
                w_lhi = mie_pkg::sx32(w_lhi);
            end
        end else begin
            if (r_lsgn) begin
                w_h = w_r - (r_la[63] ? r_lb : 64'd0) - (r_lb[63] ? r_la : 64'd0);
            end
            w_p32 = w_p;
            if (r_l32) begin
                w_llo = mie_pkg::sx32(w_p32);
                w_lhi = mie_pkg::sx32({32'd0, w_p32[63:32]});
            end else begin
                w_llo = w_p;
                w_lhi = w_h;
            end
        end
    end

    logic [63:0] r_lhi, r_llo;
    always_ff @(posedge i_clk) begin
        if (w_ldone) begin
            r_lhi <= w_lhi; r_llo <= w_llo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gpr_valid <= 32'd0;
            r_cp0_valid <= 32'd0;
            r_hi <= 64'd0; r_lo <= 64'd0;
            r_pc <= mie_pkg::RESET_PC;
            r_dslot <= 1'b0; r_dtgt <= 64'd0;
            o_next_pc <= 64'd0; o_reg_written <= 1'b0; o_reg_index <= 5'd0;
            o_reg_value <= 64'd0; o_unsupported <= 1'b0;
        end else if (i_cmd.commit) begin
            if (r_wf) begin
                r_gpr[r_wi] <= r_wv;
                r_gpr_valid[r_wi] <= 1'b1;
            end
            if (r_c0w) begin
                r_cp0[w_rd] <= r_c0v;
                r_cp0_valid[w_rd] <= 1'b1;
            end
            if (r_long) begin
                r_hi <= r_lhi; r_lo <= r_llo;
            end else begin
                if (r_hiw) r_hi <= r_hiv;
                if (r_low) r_lo <= r_lov;
            end
            if (r_dslot) begin
                r_pc <= r_dtgt; o_next_pc <= r_dtgt; r_dslot <= 1'b0;
            end else if (r_tk) begin
                r_dslot <= 1'b1; r_dtgt <= r_dest;
                r_pc <= w_cur + 64'd4; o_next_pc <= w_cur + 64'd4;
            end else if (r_skip) begin
                r_pc <= w_cur + 64'd8; o_next_pc <= w_cur + 64'd8;
            end else begin
                r_pc <= w_cur + 64'd4; o_next_pc <= w_cur + 64'd4;
            end
            o_reg_written <= r_wf; o_reg_index <= r_wi; o_reg_value <= r_wv;
            o_unsupported <= r_bad;
        end
    end

    assign o_status.is_long   = r_long;
    assign o_status.long_done = w_ldone;
endmodule

// File: rtl/core/mie_ctrl.sv
// ----------------------------------------------------------------------------
// mie_ctrl
// Sequencer of the integer execute unit: register read, execute, long start, wait, commit.
// ----------------------------------------------------------------------------
module mie_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_out_stall,
    input  mie_pkg::t_status i_status,
    output logic             o_stall,
    output logic             o_load,
    output logic             o_out_valid,
    output mie_pkg::t_cmd    o_cmd
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_EXEC = 6'b000100,
        S_LONG = 6'b001000,
        S_WAIT = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   w_free;

    // The output register may be refilled when it is empty or taken now.
    assign w_free = !r_ovalid || !i_out_stall;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && i_out_stall;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_READ;
            S_READ: begin o_cmd.read_regs = 1'b1; n_state = S_EXEC; end
            S_EXEC: begin o_cmd.execute = 1'b1; n_state = S_LONG; end
            S_LONG: begin
                if (i_status.is_long) begin
                    o_cmd.long_start = 1'b1; n_state = S_WAIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WAIT: if (i_status.long_done) n_state = S_DONE;
            S_DONE: begin
                if (w_free) begin
                    o_cmd.commit = 1'b1; n_ovalid = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_load      = (r_state == S_IDLE) && i_valid;
    assign o_out_valid = r_ovalid;
endmodule

// File: rtl/core/mips64_integer_execute_unit.sv
// ----------------------------------------------------------------------------
// mips64_integer_execute_unit
// Multicycle MIPS III integer core: one instruction word in, one result out.
// ----------------------------------------------------------------------------
// The input channel carries one 32-bit instruction word per transaction; it is
// the word at the current PC. The output channel returns, per transaction,
// the next fetch PC, the general-register write and an unsupported flag.
// Both channels use valid and stall; a transaction completes on a clock edge
// with valid high and stall low.
// Steps: each accepted instruction passes through register read, execute,
// dispatch and commit before its result is valid. Multiply and divide run
// on a shared one-bit-per-cycle unit between dispatch and commit. The next
// instruction is taken right after the commit, while the finished result may
// still wait in the output register.
// Reset (synchronous, active low) sets the PC to 0x1fc00000, clears HI, LO
// and the delay-slot state, and marks all register-file entries invalid so
// they read as zero. When the receiver stalls, the result holds; the next
// instruction writes no state and waits at commit until the output is free.
// ----------------------------------------------------------------------------
module mips64_integer_execute_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_instr,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_next_pc,
    output logic        o_reg_written,
    output logic [4:0]  o_reg_index,
    output logic [63:0] o_reg_value,
    output logic        o_unsupported
);
    mie_pkg::t_cmd    w_cmd;
    mie_pkg::t_status w_status;
    logic             w_load;

    // The controller sequences each transaction; the datapath holds state.
    mie_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_out_stall (i_stall),
        .i_status    (w_status),
        .o_stall     (o_stall),
        .o_load      (w_load),
        .o_out_valid (o_valid),
        .o_cmd       (w_cmd)
    );

    mie_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_instr       (i_instr),
        .i_load        (w_load),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_next_pc     (o_next_pc),
        .o_reg_written (o_reg_written),
        .o_reg_index   (o_reg_index),
        .o_reg_value   (o_reg_value),
        .o_unsupported (o_unsupported)
    );

    // A register write always names a nonzero register.
    a_zero_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_reg_written |-> o_reg_index != 5'd0)
        else $error("write reported to register zero");

    // Commits never come back to back.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> !w_cmd.commit)
        else $error("two commits in a row");

    // A fresh result follows each commit.
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_valid)
        else $error("commit without a valid result");
endmodule

// File: verif/mips64_integer_execute_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips64_integer_execute_unit_tb
// Self-checking testbench for the multicycle MIPS III integer execute unit.
// ----------------------------------------------------------------------------
// Instruction words are offered on the input channel. A behavioral model of
// the architectural state in this file predicts, for every accepted word, the
// next fetch PC, the register write and the unsupported flag. A checker
// compares every returned transaction with the oldest prediction. Directed
// corner cases come first, then random phases with varied idling and stalls,
// a long receiver hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module mips64_integer_execute_unit_tb;

    // Primary opcodes.
    localparam logic [5:0] OPC_SPECIAL = 6'd0,  OPC_REGIMM = 6'd1,  OPC_J     = 6'd2;
    localparam logic [5:0] OPC_JAL     = 6'd3,  OPC_BEQ    = 6'd4,  OPC_BNE   = 6'd5;
    localparam logic [5:0] OPC_BLEZ    = 6'd6,  OPC_BGTZ   = 6'd7,  OPC_ADDI  = 6'd8;
    localparam logic [5:0] OPC_ADDIU   = 6'd9,  OPC_SLTI   = 6'd10, OPC_SLTIU = 6'd11;
    localparam logic [5:0] OPC_ANDI    = 6'd12, OPC_ORI    = 6'd13, OPC_XORI  = 6'd14;
    localparam logic [5:0] OPC_LUI     = 6'd15, OPC_COP0   = 6'd16, OPC_BEQL  = 6'd20;
    localparam logic [5:0] OPC_BNEL    = 6'd21, OPC_BLEZL  = 6'd22, OPC_BGTZL = 6'd23;
    localparam logic [5:0] OPC_DADDI   = 6'd24, OPC_DADDIU = 6'd25, OPC_LW    = 6'd35;

    // Function codes of the SPECIAL group.
    localparam logic [5:0] FN_SLL    = 6'd0,  FN_SRL    = 6'd2,  FN_SRA    = 6'd3;
    localparam logic [5:0] FN_SLLV   = 6'd4,  FN_SRLV   = 6'd6,  FN_SRAV   = 6'd7;
    localparam logic [5:0] FN_JR     = 6'd8,  FN_JALR   = 6'd9,  FN_SYSCALL = 6'd12;
    localparam logic [5:0] FN_SYNC   = 6'd15, FN_MFHI   = 6'd16, FN_MTHI   = 6'd17;
    localparam logic [5:0] FN_MFLO   = 6'd18, FN_MTLO   = 6'd19, FN_DSLLV  = 6'd20;
    localparam logic [5:0] FN_DSRLV  = 6'd22, FN_DSRAV  = 6'd23, FN_MULT   = 6'd24;
    localparam logic [5:0] FN_MULTU  = 6'd25, FN_DIV    = 6'd26, FN_DIVU   = 6'd27;
    localparam logic [5:0] FN_DMULT  = 6'd28, FN_DMULTU = 6'd29, FN_DDIV   = 6'd30;
    localparam logic [5:0] FN_DDIVU  = 6'd31, FN_ADD    = 6'd32, FN_ADDU   = 6'd33;
    localparam logic [5:0] FN_SUB    = 6'd34, FN_SUBU   = 6'd35, FN_AND    = 6'd36;
    localparam logic [5:0] FN_OR     = 6'd37, FN_XOR    = 6'd38, FN_NOR    = 6'd39;
    localparam logic [5:0] FN_SLT    = 6'd42, FN_SLTU   = 6'd43, FN_DADD   = 6'd44;
    localparam logic [5:0] FN_DADDU  = 6'd45, FN_DSUB   = 6'd46, FN_DSUBU  = 6'd47;
    localparam logic [5:0] FN_DSLL   = 6'd56, FN_DSRL   = 6'd58, FN_DSRA   = 6'd59;
    localparam logic [5:0] FN_DSLL32 = 6'd60, FN_DSRL32 = 6'd62, FN_DSRA32 = 6'd63;

    // REGIMM branch selectors (rt field).
    localparam logic [4:0] RI_BLTZ   = 5'd0,  RI_BGEZ   = 5'd1,  RI_BLTZL   = 5'd2;
    localparam logic [4:0] RI_BGEZL  = 5'd3,  RI_BLTZAL = 5'd16, RI_BGEZAL  = 5'd17;
    localparam logic [4:0] RI_BLTZALL = 5'd18, RI_BGEZALL = 5'd19;

    // COP0 move selectors (rs field).
    localparam logic [4:0] C0_MF = 5'd0, C0_DMF = 5'd1, C0_MT = 5'd4, C0_DMT = 5'd5;

    localparam logic [63:0] BOOT_PC   = 64'h0000_0000_1fc0_0000;
    localparam int          IDLE_LIMIT = 5000;
    localparam int          HOLDOFF_CYCLES = 300;

    typedef struct {
        logic [63:0] next_pc;
        logic        written;
        logic [4:0]  index;
        logic [63:0] value;
        logic        unsup;
    } t_commit;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [31:0] i_instr = '0;
    logic        i_stall = 1'b0;
    logic        o_stall, o_valid, o_reg_written, o_unsupported;
    logic [63:0] o_next_pc, o_reg_value;
    logic [4:0]  o_reg_index;

    mips64_integer_execute_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_instr(i_instr),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_next_pc(o_next_pc), .o_reg_written(o_reg_written),
        .o_reg_index(o_reg_index), .o_reg_value(o_reg_value),
        .o_unsupported(o_unsupported)
    );

    always #5 i_clk = ~i_clk;

    // Architectural state as the predictor sees it.
    logic [63:0] gpr [32];
    logic [63:0] cp0 [32];
    logic [63:0] hi_q, lo_q, pc_q, slot_target;
    logic        in_slot;

    // Per-instruction effects collected while one word is evaluated.
    logic        wb_en;
    logic [4:0]  wb_ix;
    logic [63:0] wb_val;
    logic        br_go, br_skip;
    logic [63:0] br_to;

    t_commit pending_commits[$];
    int      failures = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      holdoff_left = 0;
    int      quiet_cycles = 0;

    // ------------------------------------------------------------------------
    // Predictor helpers.
    // ------------------------------------------------------------------------
    function automatic logic [63:0] sext32(input logic [63:0] x);
        return {{32{x[31]}}, x[31:0]};
    endfunction

    function automatic logic [63:0] shift_arith(input logic [63:0] x, input logic [5:0] s);
        return $unsigned($signed(x) >>> s);
    endfunction

    task automatic write_gpr(input logic [4:0] ix, input logic [63:0] v);
        // Register zero is hardwired; its writes vanish without a trace.
        if (ix != 5'd0) begin
            gpr[ix] = v;
            wb_en = 1'b1;
            wb_ix = ix;
            wb_val = v;
        end
    endtask

    task automatic set_jump(input logic [63:0] t);
        br_go = 1'b1;
        br_to = t;
        br_skip = 1'b0;
    endtask

    task automatic set_branch(input logic cond, input logic likely,
                              input logic [63:0] cur, input logic [63:0] off);
        br_go = cond;
        br_to = cur + 64'd4 + (off << 2);
        br_skip = !cond && likely;
    endtask

    task automatic divide_dw(input logic [63:0] a, input logic [63:0] b, input logic sgn);
        logic        na, nb;
        logic [63:0] ma, mb, q, r;
        if (b == 64'd0) begin
            lo_q = (sgn && a[63]) ? 64'd1 : '1;
            hi_q = a;
        end else begin
            na = sgn && a[63];
            nb = sgn && b[63];
            ma = na ? -a : a;
            mb = nb ? -b : b;
            q = ma / mb;
            r = ma % mb;
            lo_q = (na != nb) ? -q : q;
            hi_q = na ? -r : r;
        end
    endtask

    task automatic divide_word(input logic [63:0] a, input logic [63:0] b, input logic sgn);
        if (b[31:0] == 32'd0) begin
            lo_q = (sgn && a[31]) ? 64'd1 : '1;
            hi_q = sext32(a);
        end else begin
            divide_dw(sgn ? sext32(a) : {32'd0, a[31:0]},
                      sgn ? sext32(b) : {32'd0, b[31:0]}, sgn);
            lo_q = sext32(lo_q);
            hi_q = sext32(hi_q);
        end
    endtask

    task automatic multiply_dw(input logic [63:0] a, input logic [63:0] b, input logic sgn);
        logic [127:0] p;
        if (sgn)
            p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
        else
            p = {64'd0, a} * {64'd0, b};
        lo_q = p[63:0];
        hi_q = p[127:64];
    endtask

    task automatic exec_special(input logic [31:0] w, input logic [63:0] a,
                                input logic [63:0] b, input logic [63:0] cur,
                                output logic bad);
        logic [4:0]  rd, sa;
        logic [63:0] s, p;
        rd = w[15:11];
        sa = w[10:6];
        bad = 1'b0;
        case (w[5:0])
            FN_SLL:    write_gpr(rd, sext32(b << sa));
            FN_SRL:    write_gpr(rd, sext32({32'd0, b[31:0]} >> sa));
            FN_SRA:    write_gpr(rd, sext32(shift_arith(sext32(b), {1'b0, sa})));
            FN_SLLV:   write_gpr(rd, sext32(b << a[4:0]));
            FN_SRLV:   write_gpr(rd, sext32({32'd0, b[31:0]} >> a[4:0]));
            FN_SRAV:   write_gpr(rd, sext32(shift_arith(sext32(b), {1'b0, a[4:0]})));
            FN_JR:     set_jump(a);
            FN_JALR: begin
                // The target comes from rs before the link can overwrite it.
                set_jump(a);
                write_gpr(rd, cur + 64'd8);
            end
            FN_SYNC: ;
            FN_MFHI:   write_gpr(rd, hi_q);
            FN_MTHI:   hi_q = a;
            FN_MFLO:   write_gpr(rd, lo_q);
            FN_MTLO:   lo_q = a;
            FN_DSLLV:  write_gpr(rd, b << a[5:0]);
            FN_DSRLV:  write_gpr(rd, b >> a[5:0]);
            FN_DSRAV:  write_gpr(rd, shift_arith(b, a[5:0]));
            FN_MULT: begin
                p = sext32(a) * sext32(b);
                lo_q = sext32(p);
                hi_q = sext32(p >> 32);
            end
            FN_MULTU: begin
                p = {32'd0, a[31:0]} * {32'd0, b[31:0]};
                lo_q = sext32(p);
                hi_q = sext32(p >> 32);
            end
            FN_DIV:    divide_word(a, b, 1'b1);
            FN_DIVU:   divide_word(a, b, 1'b0);
            FN_DMULT:  multiply_dw(a, b, 1'b1);
            FN_DMULTU: multiply_dw(a, b, 1'b0);
            FN_DDIV:   divide_dw(a, b, 1'b1);
            FN_DDIVU:  divide_dw(a, b, 1'b0);
            FN_ADD: begin
                s = a + b;
                if ((a[31] ^ s[31]) & (b[31] ^ s[31])) bad = 1'b1;
                else write_gpr(rd, sext32(s));
            end
            FN_ADDU:   write_gpr(rd, sext32(a + b));
            FN_SUB: begin
                s = a - b;
                if ((a[31] ^ b[31]) & (a[31] ^ s[31])) bad = 1'b1;
                else write_gpr(rd, sext32(s));
            end
            FN_SUBU:   write_gpr(rd, sext32(a - b));
            FN_AND:    write_gpr(rd, a & b);
            FN_OR:     write_gpr(rd, a | b);
            FN_XOR:    write_gpr(rd, a ^ b);
            FN_NOR:    write_gpr(rd, ~(a | b));
            FN_SLT:    write_gpr(rd, {63'd0, $signed(a) < $signed(b)});
            FN_SLTU:   write_gpr(rd, {63'd0, a < b});
            FN_DADD: begin
                s = a + b;
                if ((a[63] ^ s[63]) & (b[63] ^ s[63])) bad = 1'b1;
                else write_gpr(rd, s);
            end
            FN_DADDU:  write_gpr(rd, a + b);
            FN_DSUB: begin
                s = a - b;
                if ((a[63] ^ b[63]) & (a[63] ^ s[63])) bad = 1'b1;
                else write_gpr(rd, s);
            end
            FN_DSUBU:  write_gpr(rd, a - b);
            FN_DSLL:   write_gpr(rd, b << sa);
            FN_DSRL:   write_gpr(rd, b >> sa);
            FN_DSRA:   write_gpr(rd, shift_arith(b, {1'b0, sa}));
            FN_DSLL32: write_gpr(rd, b << ({1'b0, sa} + 6'd32));
            FN_DSRL32: write_gpr(rd, b >> ({1'b0, sa} + 6'd32));
            FN_DSRA32: write_gpr(rd, shift_arith(b, {1'b0, sa} + 6'd32));
            default:   bad = 1'b1;
        endcase
    endtask

    // Evaluates one accepted word against the modeled state and queues the
    // transaction that the unit must return for it.
    task automatic execute_instr(input logic [31:0] w);
        logic [4:0]  rs, rt, sel;
        logic [63:0] a, b, cur, imm, uimm, s, jt;
        logic        bad;
        t_commit     c;
        rs = w[25:21];
        rt = w[20:16];
        a = gpr[rs];
        b = gpr[rt];
        cur = pc_q;
        imm = {{48{w[15]}}, w[15:0]};
        uimm = {48'd0, w[15:0]};
        jt = ((cur + 64'd4) & ~64'h0fff_ffff) | {36'd0, w[25:0], 2'b00};
        wb_en = 1'b0; wb_ix = '0; wb_val = '0;
        br_go = 1'b0; br_skip = 1'b0; br_to = '0;
        bad = 1'b0;
        case (w[31:26])
            OPC_SPECIAL: exec_special(w, a, b, cur, bad);
            OPC_REGIMM: begin
                sel = rt;
                case (sel)
                    RI_BLTZ, RI_BGEZ, RI_BLTZL, RI_BGEZL,
                    RI_BLTZAL, RI_BGEZAL, RI_BLTZALL, RI_BGEZALL: begin
                        // Bit 0 picks >= 0, bit 1 likely, bit 4 link.
                        set_branch(sel[0] ? !a[63] : a[63], sel[1], cur, imm);
                        if (sel[4]) write_gpr(5'd31, cur + 64'd8);
                    end
                    default: bad = 1'b1;
                endcase
            end
            OPC_J:     set_jump(jt);
            OPC_JAL: begin
                set_jump(jt);
                write_gpr(5'd31, cur + 64'd8);
            end
            OPC_BEQ:   set_branch(a == b, 1'b0, cur, imm);
            OPC_BNE:   set_branch(a != b, 1'b0, cur, imm);
            OPC_BLEZ:  set_branch(a == 64'd0 || a[63], 1'b0, cur, imm);
            OPC_BGTZ:  set_branch(a != 64'd0 && !a[63], 1'b0, cur, imm);
            OPC_BEQL:  set_branch(a == b, 1'b1, cur, imm);
            OPC_BNEL:  set_branch(a != b, 1'b1, cur, imm);
            OPC_BLEZL: set_branch(a == 64'd0 || a[63], 1'b1, cur, imm);
            OPC_BGTZL: set_branch(a != 64'd0 && !a[63], 1'b1, cur, imm);
            OPC_ADDI: begin
                s = a + imm;
                if ((a[31] ^ s[31]) & (imm[31] ^ s[31])) bad = 1'b1;
                else write_gpr(rt, sext32(s));
            end
            OPC_ADDIU: write_gpr(rt, sext32(a + imm));
            OPC_SLTI:  write_gpr(rt, {63'd0, $signed(a) < $signed(imm)});
            OPC_SLTIU: write_gpr(rt, {63'd0, a < imm});
            OPC_ANDI:  write_gpr(rt, a & uimm);
            OPC_ORI:   write_gpr(rt, a | uimm);
            OPC_XORI:  write_gpr(rt, a ^ uimm);
            OPC_LUI:   write_gpr(rt, sext32({32'd0, w[15:0], 16'd0}));
            OPC_COP0: begin
                case (rs)
                    C0_MF:   write_gpr(rt, sext32(cp0[w[15:11]]));
                    C0_DMF:  write_gpr(rt, cp0[w[15:11]]);
                    C0_MT:   cp0[w[15:11]] = sext32(b);
                    C0_DMT:  cp0[w[15:11]] = b;
                    default: bad = 1'b1;
                endcase
            end
            OPC_DADDI: begin
                s = a + imm;
                if ((a[63] ^ s[63]) & (imm[63] ^ s[63])) bad = 1'b1;
                else write_gpr(rt, s);
            end
            OPC_DADDIU: write_gpr(rt, a + imm);
            default:    bad = 1'b1;
        endcase

        // A branch sitting in a delay slot keeps its link but loses its
        // control transfer; the pending target wins.
        if (in_slot) begin
            pc_q = slot_target;
            in_slot = 1'b0;
        end else if (br_go) begin
            in_slot = 1'b1;
            slot_target = br_to;
            pc_q = cur + 64'd4;
        end else if (br_skip) begin
            pc_q = cur + 64'd8;
        end else begin
            pc_q = cur + 64'd4;
        end

        c.next_pc = pc_q;
        c.written = wb_en;
        c.index = wb_ix;
        c.value = wb_val;
        c.unsup = bad;
        pending_commits.push_back(c);
    endtask

    // ------------------------------------------------------------------------
    // Encoders and the random instruction source.
    // ------------------------------------------------------------------------
    function automatic logic [31:0] enc_r(input logic [5:0] fn, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [4:0] rd,
                                          input logic [4:0] sa);
        return {OPC_SPECIAL, rs, rt, rd, sa, fn};
    endfunction

    function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // Mostly a handful of registers, so results feed later instructions.
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 9) < 8) return 5'($urandom_range(0, 7));
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic logic [15:0] pick_imm();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'hffff;
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_instr();
        int          cls;
        logic [5:0]  op;
        logic [4:0]  sel;
        cls = $urandom_range(0, 99);
        if (cls < 8) return $urandom;
        if (cls < 42)
            return enc_r(6'($urandom_range(0, 63)), pick_reg(), pick_reg(), pick_reg(),
                         5'($urandom));
        if (cls < 50) begin
            if ($urandom_range(0, 9) == 0) sel = 5'($urandom);
            else begin
                sel = 5'($urandom_range(RI_BLTZ, RI_BGEZL));
                if ($urandom_range(0, 1)) sel = sel + (RI_BLTZAL - RI_BLTZ);
            end
            return enc_i(OPC_REGIMM, pick_reg(), sel, pick_imm());
        end
        if (cls < 68) begin
            op = 6'($urandom_range(OPC_ADDI, OPC_LUI));
            if ($urandom_range(0, 4) == 0) op = 6'($urandom_range(OPC_DADDI, OPC_DADDIU));
            return enc_i(op, pick_reg(), pick_reg(), pick_imm());
        end
        if (cls < 82) begin
            if ($urandom_range(0, 4) == 0)
                return {6'($urandom_range(OPC_J, OPC_JAL)), 26'($urandom)};
            op = 6'($urandom_range(OPC_BEQ, OPC_BGTZ));
            if ($urandom_range(0, 1)) op = op + (OPC_BEQL - OPC_BEQ);
            return enc_i(op, pick_reg(), pick_reg(), pick_imm());
        end
        if (cls < 90) begin
            case ($urandom_range(0, 4))
                0: sel = C0_MF;
                1: sel = C0_DMF;
                2: sel = C0_MT;
                3: sel = C0_DMT;
                default: sel = 5'($urandom);
            endcase
            return {OPC_COP0, sel, pick_reg(), 5'($urandom), 11'd0};
        end
        return {6'($urandom), 26'($urandom)};
    endfunction

    // ------------------------------------------------------------------------
    // Driving. Inputs move at the falling edge; acceptance is judged from the
    // values seen at the rising edge.
    // ------------------------------------------------------------------------
    task automatic send_instr(input logic [31:0] w);
        while ($urandom_range(1, 100) <= send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_instr = w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        execute_instr(w);
        @(negedge i_clk);
    endtask

    // Nothing new is offered while the outstanding transactions come back.
    task automatic wait_drained();
        i_valid = 1'b0;
        while (pending_commits.size() != 0) @(posedge i_clk);
    endtask

    // The receiver stalls at random, or solidly during a requested hold-off.
    always @(negedge i_clk) begin
        if (holdoff_left > 0) begin
            i_stall = 1'b1;
            holdoff_left = holdoff_left - 1;
        end else begin
            i_stall = ($urandom_range(1, 100) <= recv_stall_pct);
        end
    end

    // Each returned transaction is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_commit c;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_commits.size() == 0) begin
                $error("result transaction with no prediction pending");
                failures = failures + 1;
            end else begin
                c = pending_commits.pop_front();
                if (o_next_pc !== c.next_pc) begin
                    $error("next_pc: expected %h, got %h", c.next_pc, o_next_pc);
                    failures = failures + 1;
                end
                if (o_reg_written !== c.written) begin
                    $error("reg_written: expected %b, got %b", c.written, o_reg_written);
                    failures = failures + 1;
                end
                if (o_reg_index !== c.index) begin
                    $error("reg_index: expected %0d, got %0d", c.index, o_reg_index);
                    failures = failures + 1;
                end
                if (o_reg_value !== c.value) begin
                    $error("reg_value: expected %h, got %h", c.value, o_reg_value);
                    failures = failures + 1;
                end
                if (o_unsupported !== c.unsup) begin
                    $error("unsupported: expected %b, got %b", c.unsup, o_unsupported);
                    failures = failures + 1;
                end
            end
        end
    end

    // Watchdog: a run that moves nothing on either channel for too long hangs.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------
    task automatic test_corner_cases();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_instr(enc_i(OPC_LUI, 5'd0, 5'd1, 16'h8000));
        send_instr(enc_r(FN_DSLL32, 5'd0, 5'd1, 5'd1, 5'd0));     // r1 = most negative
        send_instr(enc_i(OPC_ADDIU, 5'd0, 5'd2, 16'hffff));       // r2 = -1
        send_instr(enc_r(FN_DDIV, 5'd1, 5'd2, 5'd0, 5'd0));       // signed divide overflow
        send_instr(enc_r(FN_MFLO, 5'd0, 5'd0, 5'd3, 5'd0));
        send_instr(enc_r(FN_MFHI, 5'd0, 5'd0, 5'd4, 5'd0));
        send_instr(enc_r(FN_DDIVU, 5'd2, 5'd0, 5'd0, 5'd0));      // divide by zero
        send_instr(enc_r(FN_DIV, 5'd2, 5'd0, 5'd0, 5'd0));        // negative word / 0
        send_instr(enc_r(FN_MFLO, 5'd0, 5'd0, 5'd5, 5'd0));
        send_instr(enc_r(FN_DMULT, 5'd1, 5'd2, 5'd0, 5'd0));
        send_instr(enc_r(FN_MFHI, 5'd0, 5'd0, 5'd6, 5'd0));
        send_instr(enc_i(OPC_LUI, 5'd0, 5'd7, 16'h7fff));
        send_instr(enc_r(FN_ADD, 5'd7, 5'd7, 5'd8, 5'd0));        // word overflow
        send_instr(enc_r(FN_DADD, 5'd1, 5'd1, 5'd8, 5'd0));       // doubleword overflow
        send_instr(enc_i(OPC_ADDIU, 5'd0, 5'd0, 16'h0001));       // write to register zero
        send_instr({OPC_COP0, C0_DMT, 5'd1, 5'd12, 11'd0});
        send_instr({OPC_COP0, C0_MT, 5'd2, 5'd9, 11'd0});
        send_instr({OPC_COP0, C0_DMF, 5'd9, 5'd12, 11'd0});
        send_instr({OPC_COP0, C0_MF, 5'd10, 5'd9, 11'd0});
        send_instr(enc_r(FN_JALR, 5'd3, 5'd0, 5'd3, 5'd0));       // link register == target
        send_instr(enc_i(OPC_BEQ, 5'd0, 5'd0, 16'h0010));         // branch in a delay slot
        send_instr(enc_i(OPC_BNEL, 5'd0, 5'd0, 16'h0020));        // likely, not taken: skip
        send_instr(enc_i(OPC_REGIMM, 5'd1, RI_BLTZAL, 16'hfff0)); // taken with link
        send_instr(enc_r(FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0));    // left out
        send_instr(enc_i(OPC_LW, 5'd1, 5'd2, 16'h0004));          // load: left out
        wait_drained();
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_instr(pick_instr());
    endtask

    // The receiver holds off long enough for the unit to fill and push back.
    task automatic test_output_holdoff();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        holdoff_left = HOLDOFF_CYCLES;
        repeat (40) send_instr(pick_instr());
    endtask

    // The sender stops until every prediction has been answered.
    task automatic test_drain_pause();
        test_random(20, 20, 15);
        i_valid = 1'b0;
        wait_drained();
        @(negedge i_clk);
        test_random(20, 20, 15);
    endtask

    initial begin
        for (int i = 0; i < 32; i++) begin
            gpr[i] = '0;
            cp0[i] = '0;
        end
        hi_q = '0;
        lo_q = '0;
        pc_q = BOOT_PC;
        in_slot = 1'b0;
        slot_target = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_corner_cases();
        @(negedge i_clk);
        test_random(0, 0, 150);
        test_random(62, 0, 150);
        test_random(0, 62, 150);
        test_random(31, 31, 150);
        test_output_holdoff();
        test_drain_pause();

        i_valid = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        repeat (100) @(posedge i_clk);

        if (pending_commits.size() != 0) begin
            $error("%0d predicted transactions never returned", pending_commits.size());
            failures = failures + 1;
        end
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: mips64_integer_execute_unit.f
rtl/core/mie_pkg.sv
rtl/core/mie_muldiv.sv
rtl/core/mie_datapath.sv
rtl/core/mie_ctrl.sv
rtl/core/mips64_integer_execute_unit.sv
verif/mips64_integer_execute_unit_tb.sv
